### rtl/core/assert_macros.svh
// Assertion macros shared by the keystroke line editor RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define KLE_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("line editor invariant violated");

// Check that a condition in one cycle implies another in the next cycle.
`define KLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line editor sequence violated");

`endif

### rtl/core/kle_pkg.sv
// Package for the keystroke line editor: sizes, key codes, cell commands.
// Depends on nothing; imported by every module of the block.
package kle_pkg;

    localparam int LINE_CAPACITY = 64;
    localparam int LEN_W = $clog2(LINE_CAPACITY + 1);

    localparam logic [7:0] KEY_BACKSPACE = 8'd60;
    localparam logic [7:0] KEY_HOME      = 8'd91;
    localparam logic [7:0] KEY_END       = 8'd93;
    localparam logic [7:0] KEY_NEWLINE   = 8'd10;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_DELETE,
        OP_SHIFT
    } cell_op_t;

    typedef enum logic {
        ST_EDIT,
        ST_DRAIN
    } kle_state_t;

    typedef struct packed {
        cell_op_t         op;
        logic [7:0]       key;
        logic [LEN_W-1:0] cursor;
    } cell_cmd_t;

endpackage

### rtl/core/keystroke_line_editor.sv
// Keystroke line editor: edit keys are accepted back to back while no line is draining.
// A newline stalls input while the line drains from the head of the cell chain, one
// result per cycle unless out_stall holds it. The newline enters the drain state; each
// result is then registered from cell 0, and an empty line gives one line_empty result.
// Reset (rst_n low, asynchronous) clears length, cursor, dropped flag, state and handshakes;
// cells and output byte/flag registers are not reset; cells are written before they are read.
module keystroke_line_editor (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] key_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] text_byte,
    output logic       last_of_line,
    output logic       line_empty,
    output logic       overflow_seen
);
    import kle_pkg::*;

    cell_cmd_t  cmd;
    logic [7:0] cell_data [LINE_CAPACITY];

    kle_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .key_byte      (key_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .text_byte     (text_byte),
        .last_of_line  (last_of_line),
        .line_empty    (line_empty),
        .overflow_seen (overflow_seen),
        .head_byte     (cell_data[0]),
        .cmd           (cmd)
    );

    for (genvar i = 0; i < LINE_CAPACITY; i++)
    begin : g_cell
        logic [7:0] left_in;
        logic [7:0] right_in;

        if (i == 0)
        begin : g_first
            assign left_in = 8'd0;
        end
        else
        begin : g_mid_left
            assign left_in = cell_data[i-1];
        end

        if (i == LINE_CAPACITY - 1)
        begin : g_last
            assign right_in = 8'd0;
        end
        else
        begin : g_mid_right
            assign right_in = cell_data[i+1];
        end

        kle_cell u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .idx        (LEN_W'(i)),
            .left_data  (left_in),
            .right_data (right_in),
            .data       (cell_data[i])
        );
    end

endmodule

### rtl/core/kle_cell.sv
// One character cell of the line buffer chain.
// Depends on kle_pkg; takes from its left or right neighbor on command.
module kle_cell (
    input  logic                    clk,
    input  kle_pkg::cell_cmd_t      cmd,
    input  logic [kle_pkg::LEN_W-1:0] idx,
    input  logic [7:0]              left_data,
    input  logic [7:0]              right_data,
    output logic [7:0]              data
);
    import kle_pkg::*;

    logic [7:0] data_reg;
    logic [7:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (cmd.op)
            OP_INSERT:
            begin
                if (idx == cmd.cursor)
                begin
                    data_next = cmd.key;
                end
                else if (idx > cmd.cursor)
                begin
                    data_next = left_data;
                end
            end
            OP_DELETE:
            begin
                // close the gap left by the character before the cursor
                if ((idx + LEN_W'(1)) >= cmd.cursor)
                begin
                    data_next = right_data;
                end
            end
            OP_SHIFT:
            begin
                data_next = right_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

### rtl/core/kle_ctrl.sv
// Control for the line editor: cursor, length, handshakes and line drain.
// Depends on kle_pkg and assert_macros.svh; drives the cell chain commands.
`include "assert_macros.svh"

module kle_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         key_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         text_byte,
    output logic               last_of_line,
    output logic               line_empty,
    output logic               overflow_seen,
    input  logic [7:0]         head_byte,
    output kle_pkg::cell_cmd_t cmd
);
    import kle_pkg::*;

    kle_state_t       state_reg, state_next;
    logic [LEN_W-1:0] length_reg, length_next;
    logic [LEN_W-1:0] cursor_reg, cursor_next;
    logic             dropped_reg, dropped_next;
    logic [LEN_W-1:0] cnt_reg, cnt_next;
    logic             drop_reg, drop_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       text_reg, text_next;
    logic             last_reg, last_next;
    logic             empty_reg, empty_next;
    logic             ovf_reg, ovf_next;

    logic acc;
    logic slot_free;
    logic emit;
    logic is_plain;

    assign in_stall  = (state_reg != ST_EDIT);
    assign acc       = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign emit      = (state_reg == ST_DRAIN) && slot_free;
    assign is_plain  = (key_byte != KEY_NEWLINE) && (key_byte != KEY_BACKSPACE)
                       && (key_byte != KEY_HOME) && (key_byte != KEY_END);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_EDIT:
            begin
                if (acc && key_byte == KEY_NEWLINE)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (emit && cnt_reg <= LEN_W'(1))
                begin
                    state_next = ST_EDIT;
                end
            end
            default:
            begin
                state_next = ST_EDIT;
            end
        endcase
    end

    always_comb
    begin
        cmd.op         = OP_HOLD;
        cmd.key        = key_byte;
        cmd.cursor     = cursor_reg;
        length_next    = length_reg;
        cursor_next    = cursor_reg;
        dropped_next   = dropped_reg;
        cnt_next       = cnt_reg;
        drop_next      = drop_reg;
        out_valid_next = out_valid_reg && out_stall;
        text_next      = text_reg;
        last_next      = last_reg;
        empty_next     = empty_reg;
        ovf_next       = ovf_reg;

        case (state_reg)
            ST_EDIT:
            begin
                if (acc)
                begin
                    if (key_byte == KEY_NEWLINE)
                    begin
                        cnt_next     = length_reg;
                        drop_next    = dropped_reg;
                        length_next  = '0;
                        cursor_next  = '0;
                        dropped_next = 1'b0;
                    end
                    else if (key_byte == KEY_BACKSPACE)
                    begin
                        if (cursor_reg != '0)
                        begin
                            cmd.op      = OP_DELETE;
                            cursor_next = cursor_reg - LEN_W'(1);
                            length_next = length_reg - LEN_W'(1);
                        end
                    end
                    else if (key_byte == KEY_HOME)
                    begin
                        cursor_next = '0;
                    end
                    else if (key_byte == KEY_END)
                    begin
                        cursor_next = length_reg;
                    end
                    else if (length_reg >= LEN_W'(LINE_CAPACITY))
                    begin
                        // drop the byte and remember it for this line
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        cmd.op      = OP_INSERT;
                        cursor_next = cursor_reg + LEN_W'(1);
                        length_next = length_reg + LEN_W'(1);
                    end
                end
            end
            ST_DRAIN:
            begin
                if (emit)
                begin
                    out_valid_next = 1'b1;
                    ovf_next       = drop_reg;
                    last_next      = (cnt_reg <= LEN_W'(1));
                    if (cnt_reg == '0)
                    begin
                        text_next  = 8'd0;
                        empty_next = 1'b1;
                    end
                    else
                    begin
                        // take the head cell and advance the chain
                        cmd.op     = OP_SHIFT;
                        text_next  = head_byte;
                        empty_next = 1'b0;
                        cnt_next   = cnt_reg - LEN_W'(1);
                    end
                end
            end
            default:
            begin
                cmd.op = OP_HOLD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_EDIT;
            length_reg    <= '0;
            cursor_reg    <= '0;
            dropped_reg   <= 1'b0;
            cnt_reg       <= '0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            length_reg    <= length_next;
            cursor_reg    <= cursor_next;
            dropped_reg   <= dropped_next;
            cnt_reg       <= cnt_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        text_reg  <= text_next;
        last_reg  <= last_next;
        empty_reg <= empty_next;
        ovf_reg   <= ovf_next;
    end

    assign out_valid     = out_valid_reg;
    assign text_byte     = text_reg;
    assign last_of_line  = last_reg;
    assign line_empty    = empty_reg;
    assign overflow_seen = ovf_reg;

    `KLE_ASSERT_ALWAYS(a_cursor_in_line, clk, rst_n, cursor_reg <= length_reg)
    `KLE_ASSERT_ALWAYS(a_length_bound, clk, rst_n, length_reg <= LEN_W'(LINE_CAPACITY))
    `KLE_ASSERT_NEXT(a_newline_clears, clk, rst_n, acc && key_byte == KEY_NEWLINE,
        state_reg == ST_DRAIN && length_reg == '0 && cursor_reg == '0 && !dropped_reg)
    `KLE_ASSERT_NEXT(a_last_ends_drain, clk, rst_n, emit && cnt_reg <= LEN_W'(1),
        state_reg == ST_EDIT && out_valid_reg && last_reg)
    `KLE_ASSERT_NEXT(a_plain_full_drops, clk, rst_n,
        acc && is_plain && length_reg == LEN_W'(LINE_CAPACITY), dropped_reg)

endmodule
